// ----- design/i2c_mbe_pkg.sv -----
// Package for the I2C master byte engine: word types, queue entry type,
// register indexes and sizes. No dependencies.
package i2c_mbe_pkg;

  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned Q_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STRETCH_EN  = CFG_IDX_W'(1);

  localparam logic [15:0] HALF_PERIOD_RST = 16'd60;

  typedef struct packed {
    logic       cmd_valid;
    logic       op;
    logic       start_req;
    logic       stop_req;
    logic [7:0] tx_byte;
    logic       nak;
    logic       scl_in;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] wdata;
  } cfg_word_t;

  // classified command bits held for the whole byte
  typedef struct packed {
    logic rd;
    logic stop;
    logic nak;
  } pend_t;

  typedef struct packed {
    logic       cmd_valid;
    pend_t      pend;
    logic       want_start;
    logic [7:0] tx_byte;
    logic       scl_in;
    logic       sda_in;
  } q_word_t;

endpackage

// ----- design/i2c_mbe_in_if.sv -----
// Input word channel of the I2C master byte engine.
// Depends on i2c_mbe_pkg.
interface i2c_mbe_in_if;
  import i2c_mbe_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/i2c_mbe_out_if.sv -----
// Result word channel of the I2C master byte engine.
// Depends on i2c_mbe_pkg.
interface i2c_mbe_out_if;
  import i2c_mbe_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/i2c_mbe_cfg_if.sv -----
// Register write channel of the I2C master byte engine.
// Depends on i2c_mbe_pkg.
interface i2c_mbe_cfg_if;
  import i2c_mbe_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/i2c_mbe_front.sv -----
// Front end: accepts input words, classifies the command and queues them.
// Depends on i2c_mbe_pkg and i2c_mbe_in_if.
module i2c_mbe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  i2c_mbe_in_if.sink           in_i,
  output logic                 q_valid_o,
  output i2c_mbe_pkg::q_word_t q_word_o,
  input  logic                 q_pop_i
);
  import i2c_mbe_pkg::*;

  q_word_t    mem_q [Q_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  q_word_t    cls;

  always_comb begin
    cls.cmd_valid  = in_i.data.cmd_valid;
    cls.pend.rd    = in_i.data.op;
    cls.pend.stop  = in_i.data.stop_req;
    cls.pend.nak   = in_i.data.nak;
    cls.want_start = in_i.data.start_req & ~in_i.data.op;
    cls.tx_byte    = in_i.data.tx_byte;
    cls.scl_in     = in_i.data.scl_in;
    cls.sda_in     = in_i.data.sda_in;
  end

  assign in_i.ready = (cnt_q != 2'(Q_DEPTH));
  assign push       = in_i.valid & in_i.ready;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i & q_valid_o;
  assign q_word_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- design/i2c_mbe_back.sv -----
// Back end: bus phase sequencer, delay counter, config registers and
// result register. Depends on i2c_mbe_pkg, i2c_mbe_cfg_if, i2c_mbe_out_if.
module i2c_mbe_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  i2c_mbe_pkg::q_word_t q_word_i,
  output logic                 q_pop_o,
  i2c_mbe_cfg_if.sink          cfg_i,
  i2c_mbe_out_if.source        out_o
);
  import i2c_mbe_pkg::*;

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_RS_SETUP = 4'd1;
  localparam logic [3:0] PH_RS_WAIT  = 4'd2;
  localparam logic [3:0] PH_ST_HOLD  = 4'd3;
  localparam logic [3:0] PH_BIT_SET  = 4'd4;
  localparam logic [3:0] PH_BIT_WAIT = 4'd5;
  localparam logic [3:0] PH_BIT_HIGH = 4'd6;
  localparam logic [3:0] PH_SP_SETUP = 4'd7;
  localparam logic [3:0] PH_SP_WAIT  = 4'd8;
  localparam logic [3:0] PH_SP_HOLD  = 4'd9;

  logic [15:0]        half_q;
  logic               stretch_q;
  logic [3:0]         phase_q, phase_d;
  logic [3:0]         bit_q, bit_d;
  logic [7:0]         shift_q, shift_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic               started_q, started_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  pend_t              pend_q, pend_d;
  logic [7:0]         rx_q, rx_d;
  logic               nack_q, nack_d;
  logic               out_valid_q;
  out_word_t          out_data_q;

  logic               pop, done, do_setup, expired, scl_ok;
  logic [DELAY_W-1:0] delay_load;

  assign cfg_i.ready = 1'b1;
  assign pop         = q_valid_i & (~out_valid_q | out_o.ready);
  assign q_pop_o     = pop;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  assign delay_load = DELAY_W'(half_q);
  assign expired    = (delay_q <= DELAY_W'(1));
  assign scl_ok     = ~stretch_q | q_word_i.scl_in;

  always_comb begin
    phase_d   = phase_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    delay_d   = delay_q;
    started_d = started_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    pend_d    = pend_q;
    rx_d      = rx_q;
    nack_d    = nack_q;
    done      = 1'b0;
    do_setup  = 1'b0;
    if (pop) begin
      case (phase_q)
        PH_IDLE: begin
          if (q_word_i.cmd_valid) begin
            pend_d  = q_word_i.pend;
            shift_d = q_word_i.pend.rd ? 8'd0 : q_word_i.tx_byte;
            bit_d   = 4'd0;
            if (q_word_i.want_start) begin
              if (started_q) begin
                sda_d   = 1'b0;
                phase_d = PH_RS_SETUP;
              end else begin
                sda_d   = 1'b1;
                phase_d = PH_ST_HOLD;
              end
              delay_d = delay_load;
            end else begin
              do_setup = 1'b1;
            end
          end
        end
        PH_RS_SETUP: begin
          if (expired) begin
            scl_d   = 1'b0;
            phase_d = PH_RS_WAIT;
          end else begin
            delay_d = delay_q - DELAY_W'(1);
          end
        end
        PH_RS_WAIT: begin
          if (scl_ok) begin
            sda_d   = 1'b1;
            phase_d = PH_ST_HOLD;
            delay_d = delay_load;
          end
        end
        PH_ST_HOLD: begin
          if (expired) begin
            scl_d     = 1'b1;
            started_d = 1'b1;
            do_setup  = 1'b1;
          end else begin
            delay_d = delay_q - DELAY_W'(1);
          end
        end
        PH_BIT_SET: begin
          if (expired) begin
            scl_d   = 1'b0;
            phase_d = PH_BIT_WAIT;
          end else begin
            delay_d = delay_q - DELAY_W'(1);
          end
        end
        PH_BIT_WAIT: begin
          if (scl_ok) begin
            if (bit_q < 4'(BYTE_BITS)) begin
              if (pend_q.rd) begin
                shift_d = {shift_q[6:0], q_word_i.sda_in};
              end
            end else if (!pend_q.rd) begin
              nack_d = q_word_i.sda_in;
            end
            phase_d = PH_BIT_HIGH;
            delay_d = delay_load;
          end
        end
        PH_BIT_HIGH: begin
          if (expired) begin
            scl_d = 1'b1;
            if (bit_q < 4'(BYTE_BITS)) begin
              if (!pend_q.rd) begin
                shift_d = {shift_q[6:0], 1'b0};
              end
              bit_d    = bit_q + 4'd1;
              do_setup = 1'b1;
            end else begin
              if (pend_q.rd) begin
                rx_d = shift_q;
              end
              if (pend_q.stop) begin
                sda_d   = 1'b1;
                phase_d = PH_SP_SETUP;
                delay_d = delay_load;
              end else begin
                phase_d = PH_IDLE;
                done    = 1'b1;
              end
            end
          end else begin
            delay_d = delay_q - DELAY_W'(1);
          end
        end
        PH_SP_SETUP: begin
          if (expired) begin
            scl_d   = 1'b0;
            phase_d = PH_SP_WAIT;
          end else begin
            delay_d = delay_q - DELAY_W'(1);
          end
        end
        PH_SP_WAIT: begin
          if (scl_ok) begin
            sda_d   = 1'b0;
            phase_d = PH_SP_HOLD;
            delay_d = delay_load;
          end
        end
        PH_SP_HOLD: begin
          if (expired) begin
            started_d = 1'b0;
            phase_d   = PH_IDLE;
            done      = 1'b1;
          end else begin
            delay_d = delay_q - DELAY_W'(1);
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
      // drive next bit (or ack slot) and open its low half
      if (do_setup) begin
        if (bit_d < 4'(BYTE_BITS)) begin
          sda_d = pend_d.rd ? 1'b0 : ~shift_d[7];
        end else begin
          sda_d = pend_d.rd ? ~pend_d.nak : 1'b0;
        end
        phase_d = PH_BIT_SET;
        delay_d = delay_load;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= HALF_PERIOD_RST;
      stretch_q   <= 1'b1;
      phase_q     <= PH_IDLE;
      bit_q       <= 4'd0;
      shift_q     <= 8'd0;
      delay_q     <= '0;
      started_q   <= 1'b0;
      scl_q       <= 1'b0;
      sda_q       <= 1'b0;
      pend_q      <= '0;
      rx_q        <= 8'd0;
      nack_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          REG_HALF_PERIOD: half_q    <= cfg_i.data.wdata;
          REG_STRETCH_EN:  stretch_q <= cfg_i.data.wdata[0];
          default: ;
        endcase
      end
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      delay_q   <= delay_d;
      started_q <= started_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
      pend_q    <= pend_d;
      rx_q      <= rx_d;
      nack_q    <= nack_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_data_q.scl_low   <= scl_d;
      out_data_q.sda_low   <= sda_d;
      out_data_q.busy_res  <= (phase_d != PH_IDLE);
      out_data_q.done_res  <= done;
      out_data_q.rx_byte   <= rx_d;
      out_data_q.nack_seen <= nack_d;
    end
  end

endmodule

// ----- design/i2c_master_byte_engine.sv -----
// I2C master byte engine, top level: front queue feeding the bus sequencer.
// An accepted input word reaches its result word through one queue slot
// and then the result register. Throughput: one word per cycle while the
// result channel accepts, set by the single-step phase sequencer. Reset
// (async, active low) clears the queue, idles the sequencer, releases both
// pins and restores the registers to half period 60 and stretching on.
module i2c_master_byte_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2c_mbe_in_if.sink    in_ch_i,
  i2c_mbe_cfg_if.sink   cfg_i,
  i2c_mbe_out_if.source out_ch_o
);
  import i2c_mbe_pkg::*;

  logic    q_valid;
  logic    q_pop;
  q_word_t q_word;

  i2c_mbe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch_i),
    .q_valid_o (q_valid),
    .q_word_o  (q_word),
    .q_pop_i   (q_pop)
  );

  i2c_mbe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_word_i  (q_word),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg_i),
    .out_o     (out_ch_o)
  );

endmodule
